FILE: sv/tme_pkg.sv
// ----------------------------------------------------------------------------
// tme_pkg: shared types and codes for the three-pass modexp cipher unit
// Holds the command codes, register indexes and the control group that
// travels beside the data through every pipeline stage.
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int ADDR_BITS = 4;

  typedef enum logic [1:0] {
    CMD_LOCK   = 2'd0,
    CMD_UNLOCK = 2'd1,
    CMD_FINAL  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MODULUS    = 2'd0,
    REG_LOCK_EXP   = 2'd1,
    REG_UNLOCK_EXP = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic unlock;
    logic trunc;
    logic last;
  } ctl_t;

endpackage

FILE: sv/three_pass_modexp_cipher_unit.sv
// ----------------------------------------------------------------------------
// three_pass_modexp_cipher_unit: one party's step of the three-pass cipher
// Raises each input word to the lock or unlock exponent modulo the modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (command, value, last_in) enter on in_valid/in_ready; one
//   result beat (result, last_out) leaves on out_valid/out_ready per input.
//   Configure modulus, lock_exponent and unlock_exponent over the APB port
//   (byte addresses 0, 4, 8) while no beat is in flight.
//   The pipeline runs WORD_BITS reduction steps, then WORD_BITS exponent
//   bits of WORD_BITS shift-and-add multiply steps each, one step per
//   register stage.
//   Throughput is one beat per cycle while the receiver takes results.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
//   Reset empties the pipeline and loads modulus 3 and both exponents 1.
//   Modulus zero or one gives result zero; command 3 acts as a final unlock.
// ----------------------------------------------------------------------------
module three_pass_modexp_cipher_unit
  import tme_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [WORD_BITS-1:0] value,
  input  logic                 last_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] result,
  output logic                 last_out
);

  localparam int W  = WORD_BITS;
  localparam int CW = (W < 32) ? W : 32;
  localparam int N  = W + W * W;

  logic [W-1:0] modulus, lock_exponent, unlock_exponent;
  reg_idx_t     widx;
  logic         adv;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus         <= W'(3);
      lock_exponent   <= W'(1);
      unlock_exponent <= W'(1);
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_MODULUS:    modulus         <= W'(pwdata[CW-1:0]);
        REG_LOCK_EXP:   lock_exponent   <= W'(pwdata[CW-1:0]);
        REG_UNLOCK_EXP: unlock_exponent <= W'(pwdata[CW-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MODULUS:    prdata = 32'(modulus);
      REG_LOCK_EXP:   prdata = 32'(lock_exponent);
      REG_UNLOCK_EXP: prdata = 32'(unlock_exponent);
      default:        prdata = '0;
    endcase
  end

  ctl_t         ctl_s [0:N];
  logic [W-1:0] rem_s [0:W];
  logic [W-1:0] val_s [0:W];
  logic [W-1:0] acc_s [W:N];
  logic [W-1:0] b_s   [W:N];
  logic [W-1:0] ra_s  [W:N];
  logic [W-1:0] rs_s  [W:N];

  assign adv      = !ctl_s[N].valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    ctl_s[0].valid  = in_valid;
    ctl_s[0].unlock = (cmd_t'(command) != CMD_LOCK);
    // bit 1 marks the byte-truncating unlock, reserved code included
    ctl_s[0].trunc  = command[1];
    ctl_s[0].last   = last_in;
  end
  assign rem_s[0] = '0;
  assign val_s[0] = value;

  for (genvar i = 0; i < W; i++) begin : g_div
    tme_div_stage #(.W(W), .BIT(W - 1 - i)) u_div (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .modulus (modulus),
      .ctl_in  (ctl_s[i]),
      .rem_in  (rem_s[i]),
      .val_in  (val_s[i]),
      .ctl_out (ctl_s[i+1]),
      .rem_out (rem_s[i+1]),
      .val_out (val_s[i+1])
    );
  end

  // acc starts at 1 mod m
  assign acc_s[W] = (modulus == W'(1)) ? '0 : W'(1);
  assign b_s[W]   = rem_s[W];
  assign ra_s[W]  = '0;
  assign rs_s[W]  = '0;

  for (genvar k = 0; k < W; k++) begin : g_exp
    for (genvar j = 0; j < W; j++) begin : g_step
      localparam int S = W + k * W + j;
      logic ebit;
      assign ebit = ctl_s[S].unlock ? unlock_exponent[k] : lock_exponent[k];

      tme_mul_stage #(
        .W     (W),
        .BIT   (W - 1 - j),
        .FIRST (j == 0),
        .LAST  (j == W - 1)
      ) u_mul (
        .clk     (clk),
        .rst     (rst),
        .adv     (adv),
        .modulus (modulus),
        .ebit    (ebit),
        .ctl_in  (ctl_s[S]),
        .acc_in  (acc_s[S]),
        .b_in    (b_s[S]),
        .ra_in   (ra_s[S]),
        .rs_in   (rs_s[S]),
        .ctl_out (ctl_s[S+1]),
        .acc_out (acc_s[S+1]),
        .b_out   (b_s[S+1]),
        .ra_out  (ra_s[S+1]),
        .rs_out  (rs_s[S+1])
      );
    end
  end

  assign out_valid = ctl_s[N].valid;
  assign last_out  = ctl_s[N].last;

  always_comb begin
    if (modulus == '0) begin
      result = '0;
    end else if (ctl_s[N].trunc) begin
      result = W'(acc_s[N][7:0]);
    end else begin
      result = acc_s[N];
    end
  end

endmodule

FILE: sv/tme_div_stage.sv
// ----------------------------------------------------------------------------
// tme_div_stage: one restoring step of the input reduction
// Shifts one input bit into the partial remainder and subtracts the modulus
// when the remainder reaches it.
// ----------------------------------------------------------------------------
module tme_div_stage
  import tme_pkg::*;
#(
  parameter int W   = 32,
  parameter int BIT = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic [W-1:0] modulus,
  input  ctl_t         ctl_in,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] val_in,
  output ctl_t         ctl_out,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] val_out
);

  logic [W:0]   shifted;
  logic [W-1:0] rem_next;

  always_comb begin
    shifted = {rem_in, val_in[BIT]};
    if (shifted >= {1'b0, modulus}) begin
      rem_next = W'(shifted - {1'b0, modulus});
    end else begin
      rem_next = shifted[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out <= rem_next;
      val_out <= val_in;
    end
  end

endmodule

FILE: sv/tme_mul_stage.sv
// ----------------------------------------------------------------------------
// tme_mul_stage: one shift-and-add step of the two modular products
// Advances acc*b and b*b by one multiplier bit; the last step of an exponent
// bit folds acc*b into the accumulator when that bit is set, and b*b into the squared base.
// ----------------------------------------------------------------------------
module tme_mul_stage
  import tme_pkg::*;
#(
  parameter int W     = 32,
  parameter int BIT   = 31,
  parameter bit FIRST = 1'b0,
  parameter bit LAST  = 1'b0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic [W-1:0] modulus,
  input  logic         ebit,
  input  ctl_t         ctl_in,
  input  logic [W-1:0] acc_in,
  input  logic [W-1:0] b_in,
  input  logic [W-1:0] ra_in,
  input  logic [W-1:0] rs_in,
  output ctl_t         ctl_out,
  output logic [W-1:0] acc_out,
  output logic [W-1:0] b_out,
  output logic [W-1:0] ra_out,
  output logic [W-1:0] rs_out
);

  // (x + y) mod m for x, y below m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                           input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W-1:0] room;
    room = m - y;
    if (x >= room) begin
      return x - room;
    end
    return x + y;
  endfunction

  logic [W-1:0] ra_src, rs_src, ra_next, rs_next;

  always_comb begin
    ra_src  = FIRST ? '0 : ra_in;
    rs_src  = FIRST ? '0 : rs_in;
    ra_next = add_mod(ra_src, ra_src, modulus);
    rs_next = add_mod(rs_src, rs_src, modulus);
    if (b_in[BIT]) begin
      ra_next = add_mod(ra_next, acc_in, modulus);
      rs_next = add_mod(rs_next, b_in, modulus);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ra_out <= ra_next;
      rs_out <= rs_next;
      if (LAST) begin
        acc_out <= ebit ? ra_next : acc_in;
        b_out   <= rs_next;
      end else begin
        acc_out <= acc_in;
        b_out   <= b_in;
      end
    end
  end

endmodule

FILE: sv/tme_checker.sv
// ----------------------------------------------------------------------------
// tme_checker: port-level checks for the three-pass modexp cipher unit
// Watches the stream handshakes and the config port over time.
// ----------------------------------------------------------------------------
module tme_checker
  import tme_pkg::*;
#(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] result,
  input logic         last_out,
  input logic         pready
);

  // pipeline is empty right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result) && $stable(last_out))
    else $error("stalled result beat changed");

  // input side stalls exactly when a waiting result is not taken
  assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("config port not ready");

endmodule

bind three_pass_modexp_cipher_unit tme_checker #(.W(WORD_BITS)) u_tme_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .result    (result),
  .last_out  (last_out),
  .pready    (pready)
);
